// File: hw/rtl/pic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types, codes and helper functions for the interrupt controller.
// ----------------------------------------------------------------------------
package pic_pkg;

    // Transaction kinds on the input channel
    typedef enum logic [1:0] {
        FUNC_READ   = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_SAMPLE = 2'd2,
        FUNC_ACK    = 2'd3
    } func_t;

    // Initialisation sequence position
    typedef enum logic [1:0] {
        PHASE_READY = 2'd0,
        PHASE_ICW2  = 2'd1,
        PHASE_ICW3  = 2'd2,
        PHASE_ICW4  = 2'd3
    } phase_t;

    // Port select codes
    localparam logic PORT_CMD  = 1'b0;
    localparam logic PORT_DATA = 1'b1;

    // Command word decode bits
    localparam int ICW1_BIT      = 4;
    localparam int OCW3_BIT      = 3;
    localparam int OCW3_RR_BIT   = 1;
    localparam int OCW3_RIS_BIT  = 0;
    localparam int ICW1_IC4_BIT  = 0;
    localparam int ICW1_SNGL_BIT = 1;
    localparam int ICW1_LTIM_BIT = 3;
    localparam int ICW4_AEOI_BIT = 1;

    // OCW2 command codes in bits 7..5
    localparam logic [2:0] EOI_NONSPEC = 3'b001;
    localparam logic [2:0] EOI_SPEC    = 3'b011;

    // Spurious level reported when no request qualifies
    localparam logic [2:0] SPURIOUS_LEVEL = 3'd7;

    // Index of lowest set bit; bit 3 set means none
    function automatic logic [3:0] lowest_set(input logic [7:0] v);
        logic [3:0] idx;
        idx = 4'd8;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

    // Unmasked requests above every in-service level
    function automatic logic [7:0] eligible(input logic [7:0] req,
                                            input logic [7:0] mask,
                                            input logic [7:0] serv);
        logic [7:0] below;
        // bits strictly below lowest in-service bit; all ones when none
        below = (serv - 8'd1) & ~serv;
        return req & ~mask & below;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pic_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pic_if
// Valid/ready channels for controller transactions and their results.
// ----------------------------------------------------------------------------
interface pic_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic       port_select;
    logic [7:0] write_data;
    logic [7:0] request_lines;

    modport source (output valid, output func, output port_select,
                    output write_data, output request_lines, input ready);
    modport sink   (input valid, input func, input port_select,
                    input write_data, input request_lines, output ready);
endinterface

interface pic_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] vector;
    logic       vector_valid;
    logic       int_pending;
    logic       init_busy;

    modport source (output valid, output read_data, output vector,
                    output vector_valid, output int_pending, output init_busy,
                    input ready);
    modport sink   (input valid, input read_data, input vector,
                    input vector_valid, input int_pending, input init_busy,
                    output ready);
endinterface
`default_nettype wire

// File: hw/rtl/programmable_interrupt_controller_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// programmable_interrupt_controller_core
// An accepted transaction's result appears in the output register in the
// next cycle. Throughput: one transaction per cycle while out_ch is not stalled,
// set by the single register stage around the state update and priority encoder.
// Reset: rst_n clears all controller state and empties the output register.
// Single-chip 8259A-style controller: init words, mask, request and
// in-service registers, EOI handling and vector generation on acknowledge.
// ----------------------------------------------------------------------------
module programmable_interrupt_controller_core (
    input  wire logic clk,
    input  wire logic rst_n,
    pic_in_if.sink    in_ch,
    pic_out_if.source out_ch
);
    import pic_pkg::*;

    // Controller state
    phase_t     phase_reg,   phase_next;
    logic       need4_reg,   need4_next;
    logic       single_reg,  single_next;
    logic       level_reg,   level_next;
    logic       aeoi_reg,    aeoi_next;
    logic [4:0] base_reg,    base_next;
    logic [7:0] mask_reg,    mask_next;
    logic [7:0] req_reg,     req_next;
    logic [7:0] serv_reg,    serv_next;
    logic       rsel_reg,    rsel_next;
    logic [7:0] last_reg,    last_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] rd_reg,      rd_next;
    logic [7:0] vec_reg,     vec_next;
    logic       vvalid_reg,  vvalid_next;
    logic       pend_reg,    pend_next;
    logic       busy_reg,    busy_next;

    logic       accept;
    logic [7:0] wd;
    logic [7:0] elig_now;
    logic [3:0] winner;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign wd          = in_ch.write_data;

    // Acknowledge arbitration on current state
    assign elig_now = eligible(req_reg, mask_reg, serv_reg);
    assign winner   = lowest_set(elig_now);

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        need4_next  = need4_reg;
        single_next = single_reg;
        level_next  = level_reg;
        aeoi_next   = aeoi_reg;
        base_next   = base_reg;
        mask_next   = mask_reg;
        req_next    = req_reg;
        serv_next   = serv_reg;
        rsel_next   = rsel_reg;
        last_next   = last_reg;

        case (func_t'(in_ch.func))
            FUNC_WRITE:
            begin
                if (in_ch.port_select == PORT_DATA)
                begin
                    case (phase_reg)
                        PHASE_ICW2:
                        begin
                            base_next = wd[7:3];
                            if (!single_reg)
                                phase_next = PHASE_ICW3;
                            else
                                phase_next = need4_reg ? PHASE_ICW4 : PHASE_READY;
                        end
                        PHASE_ICW3:
                        begin
                            // cascade word carries nothing for a single chip
                            phase_next = need4_reg ? PHASE_ICW4 : PHASE_READY;
                        end
                        PHASE_ICW4:
                        begin
                            aeoi_next  = wd[ICW4_AEOI_BIT];
                            phase_next = PHASE_READY;
                        end
                        default:
                        begin
                            mask_next = wd;
                        end
                    endcase
                end
                else if (wd[ICW1_BIT])
                begin
                    // ICW1 restarts initialisation from any phase
                    need4_next  = wd[ICW1_IC4_BIT];
                    single_next = wd[ICW1_SNGL_BIT];
                    level_next  = wd[ICW1_LTIM_BIT];
                    mask_next   = '0;
                    req_next    = '0;
                    serv_next   = '0;
                    last_next   = '0;
                    rsel_next   = 1'b0;
                    aeoi_next   = 1'b0;
                    phase_next  = PHASE_ICW2;
                end
                else if (phase_reg == PHASE_READY)
                begin
                    if (wd[OCW3_BIT])
                    begin
                        if (wd[OCW3_RR_BIT])
                            rsel_next = wd[OCW3_RIS_BIT];
                    end
                    else
                    begin
                        case (wd[7:5])
                            EOI_NONSPEC: serv_next = serv_reg & (serv_reg - 8'd1);
                            EOI_SPEC:    serv_next = serv_reg & ~(8'd1 << wd[2:0]);
                            default:     serv_next = serv_reg;
                        endcase
                    end
                end
            end
            FUNC_SAMPLE:
            begin
                if (level_reg)
                    req_next = in_ch.request_lines;
                else
                    req_next = req_reg | (in_ch.request_lines & ~last_reg);
                last_next = in_ch.request_lines;
            end
            FUNC_ACK:
            begin
                if (!winner[3])
                begin
                    req_next = req_reg & ~(8'd1 << winner[2:0]);
                    if (!aeoi_reg)
                        serv_next = serv_reg | (8'd1 << winner[2:0]);
                end
            end
            default:
            begin
                // bus read has no side effects
            end
        endcase
    end

    // Result fields
    always_comb
    begin
        rd_next     = '0;
        vec_next    = '0;
        vvalid_next = 1'b0;
        case (func_t'(in_ch.func))
            FUNC_READ:
            begin
                if (in_ch.port_select == PORT_DATA)
                    rd_next = mask_reg;
                else
                    rd_next = rsel_reg ? serv_reg : req_reg;
            end
            FUNC_ACK:
            begin
                vvalid_next = 1'b1;
                vec_next    = {base_reg, winner[3] ? SPURIOUS_LEVEL : winner[2:0]};
            end
            default:
            begin
                rd_next = '0;
            end
        endcase
        pend_next = |eligible(req_next, mask_next, serv_next);
        busy_next = (phase_next != PHASE_READY);
    end

    // Output register valid
    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PHASE_READY;
            need4_reg     <= 1'b0;
            single_reg    <= 1'b0;
            level_reg     <= 1'b0;
            aeoi_reg      <= 1'b0;
            base_reg      <= '0;
            mask_reg      <= '0;
            req_reg       <= '0;
            serv_reg      <= '0;
            rsel_reg      <= 1'b0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg  <= phase_next;
                need4_reg  <= need4_next;
                single_reg <= single_next;
                level_reg  <= level_next;
                aeoi_reg   <= aeoi_next;
                base_reg   <= base_next;
                mask_reg   <= mask_next;
                req_reg    <= req_next;
                serv_reg   <= serv_next;
                rsel_reg   <= rsel_next;
                last_reg   <= last_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg     <= rd_next;
            vec_reg    <= vec_next;
            vvalid_reg <= vvalid_next;
            pend_reg   <= pend_next;
            busy_reg   <= busy_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.read_data    = rd_reg;
    assign out_ch.vector       = vec_reg;
    assign out_ch.vector_valid = vvalid_reg;
    assign out_ch.int_pending  = pend_reg;
    assign out_ch.init_busy    = busy_reg;

endmodule
`default_nettype wire

// File: hw/rtl/pic_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pic_checker
// Port-level checks on the controller: result content and transaction flow.
// ----------------------------------------------------------------------------
module pic_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [1:0] in_func,
    input wire logic       in_port_select,
    input wire logic [7:0] in_write_data,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_read_data,
    input wire logic [7:0] out_vector,
    input wire logic       out_vector_valid,
    input wire logic       out_init_busy
);
    import pic_pkg::*;

    // An acknowledge yields a vector result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_func == FUNC_ACK)
        |=> out_valid && out_vector_valid)
    else $error("acknowledge did not produce a vector result");

    // ICW1 always leaves the init sequence busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_func == FUNC_WRITE)
        && (in_port_select == PORT_CMD) && in_write_data[ICW1_BIT]
        |=> out_valid && out_init_busy)
    else $error("ICW1 did not start initialisation");

    // Vector and read data never both carry content
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_vector_valid ? (out_read_data == 8'd0)
                                        : (out_vector == 8'd0)))
    else $error("result carries both read data and vector");

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready
        |=> out_valid && $stable(out_read_data) && $stable(out_vector))
    else $error("stalled result changed");

endmodule

bind programmable_interrupt_controller_core pic_checker u_pic_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_func          (in_ch.func),
    .in_port_select   (in_ch.port_select),
    .in_write_data    (in_ch.write_data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_read_data    (out_ch.read_data),
    .out_vector       (out_ch.vector),
    .out_vector_valid (out_ch.vector_valid),
    .out_init_busy    (out_ch.init_busy)
);
`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the single-chip interrupt controller. A short
// directed run walks the init sequence, masking, acknowledge, both EOI forms,
// read select and the spurious vector. A long random run follows: mostly
// well-formed init sequences, samples, acknowledges and EOIs, with noise.
// Every result is checked against the in-bench model or a fixed answer. Both
// channels idle at random, and the result side holds off once for a long
// stretch so that the core stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
    import pic_pkg::*;

    localparam int RANDOM_TXNS  = 1500;
    localparam int MAX_WAIT     = 12;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 8;

    // One input transaction
    typedef struct packed {
        func_t      f;
        logic       port;
        logic [7:0] wd;
        logic [7:0] lines;
    } txn_t;

    // One result transaction
    typedef struct packed {
        logic [7:0] rd;
        logic [7:0] vec;
        logic       vv;
        logic       pend;
        logic       busy;
    } answer_t;

    // Directed row: transaction plus an optional hand-written answer
    typedef struct packed {
        txn_t    t;
        logic    fixed;
        answer_t ans;
    } dir_row_t;

    localparam answer_t NO_ANS = '0;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #10 clk = ~clk;
    end

    pic_in_if  in_ch ();
    pic_out_if out_ch ();

    programmable_interrupt_controller_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Controller model state
    phase_t     m_phase;
    logic       m_ic4;
    logic       m_sngl;
    logic       m_ltim;
    logic       m_aeoi;
    logic [4:0] m_base;
    logic [7:0] m_cascade;
    logic [7:0] m_imr;
    logic [7:0] m_irr;
    logic [7:0] m_isr;
    logic       m_ris;
    logic [7:0] m_last;

    answer_t answers_due[$];
    txn_t    stim_q[$];
    logic [7:0] line_levels = 8'h00;
    int      mismatches    = 0;
    int      results_taken = 0;
    int      idle_cycles   = 0;

    // Lowest set bit, 8 when the byte is clear
    function automatic int first_set(logic [7:0] v);
        int k;
        k = 8;
        for (int i = 0; i < 8; i++)
        begin
            if (v[i] && k == 8)
            begin
                k = i;
            end
        end
        return k;
    endfunction

    // Unmasked requests that outrank everything in service
    function automatic logic [7:0] serviceable();
        logic [7:0] p;
        int s;
        p = m_irr & ~m_imr;
        s = first_set(m_isr);
        if (s < 8)
        begin
            p = p & ((8'd1 << s) - 8'd1);
        end
        return p;
    endfunction

    // Advance the model by one transaction and return the answer it gives
    function automatic answer_t next_answer(txn_t t);
        answer_t a;
        int w;
        a = NO_ANS;
        case (t.f)
            FUNC_READ:
            begin
                if (t.port == PORT_DATA)
                begin
                    a.rd = m_imr;
                end
                else
                begin
                    a.rd = m_ris ? m_isr : m_irr;
                end
            end
            FUNC_WRITE:
            begin
                if (t.port == PORT_DATA)
                begin
                    case (m_phase)
                        PHASE_ICW2:
                        begin
                            m_base = t.wd[7:3];
                            if (!m_sngl)
                            begin
                                m_phase = PHASE_ICW3;
                            end
                            else
                            begin
                                m_phase = m_ic4 ? PHASE_ICW4 : PHASE_READY;
                            end
                        end
                        PHASE_ICW3:
                        begin
                            m_cascade = t.wd;
                            m_phase   = m_ic4 ? PHASE_ICW4 : PHASE_READY;
                        end
                        PHASE_ICW4:
                        begin
                            m_aeoi  = t.wd[ICW4_AEOI_BIT];
                            m_phase = PHASE_READY;
                        end
                        default:
                        begin
                            m_imr = t.wd;
                        end
                    endcase
                end
                else if (t.wd[ICW1_BIT])
                begin
                    // ICW1 restarts init from any phase
                    m_ic4   = t.wd[ICW1_IC4_BIT];
                    m_sngl  = t.wd[ICW1_SNGL_BIT];
                    m_ltim  = t.wd[ICW1_LTIM_BIT];
                    m_imr   = 8'h00;
                    m_irr   = 8'h00;
                    m_isr   = 8'h00;
                    m_last  = 8'h00;
                    m_ris   = 1'b0;
                    m_aeoi  = 1'b0;
                    m_phase = PHASE_ICW2;
                end
                else if (m_phase != PHASE_READY)
                begin
                    // other command words are dropped mid-init
                end
                else if (t.wd[OCW3_BIT])
                begin
                    if (t.wd[OCW3_RR_BIT])
                    begin
                        m_ris = t.wd[OCW3_RIS_BIT];
                    end
                end
                else if (t.wd[7:5] == EOI_NONSPEC)
                begin
                    w = first_set(m_isr);
                    if (w < 8)
                    begin
                        m_isr[w] = 1'b0;
                    end
                end
                else if (t.wd[7:5] == EOI_SPEC)
                begin
                    m_isr[t.wd[2:0]] = 1'b0;
                end
            end
            FUNC_SAMPLE:
            begin
                if (m_ltim)
                begin
                    m_irr = t.lines;
                end
                else
                begin
                    m_irr = m_irr | (t.lines & ~m_last);
                end
                m_last = t.lines;
            end
            default:
            begin
                w = first_set(serviceable());
                a.vv = 1'b1;
                if (w < 8)
                begin
                    m_irr[w] = 1'b0;
                    if (!m_aeoi)
                    begin
                        m_isr[w] = 1'b1;
                    end
                    a.vec = {m_base, 3'(w)};
                end
                else
                begin
                    a.vec = {m_base, SPURIOUS_LEVEL};
                end
            end
        endcase
        a.pend = |serviceable();
        a.busy = (m_phase != PHASE_READY);
        return a;
    endfunction

    function automatic txn_t op(func_t f, logic port, logic [7:0] wd, logic [7:0] lines);
        txn_t t;
        t.f     = f;
        t.port  = port;
        t.wd    = wd;
        t.lines = lines;
        return t;
    endfunction

    function automatic txn_t rand_txn();
        return op(func_t'($urandom_range(0, 3)), 1'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // Queue up the next random transaction, or a whole init sequence
    task automatic plan_random();
        int pick;
        logic [7:0] icw1;
        logic [7:0] wd;
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            icw1 = (8'($urandom) & 8'hEF) | 8'h10;
            stim_q.push_back(op(FUNC_WRITE, PORT_CMD, icw1, 8'($urandom)));
            stim_q.push_back(op(FUNC_WRITE, PORT_DATA, 8'($urandom), 8'($urandom)));
            if (!icw1[ICW1_SNGL_BIT])
            begin
                stim_q.push_back(op(FUNC_WRITE, PORT_DATA, 8'($urandom), 8'($urandom)));
            end
            if (icw1[ICW1_IC4_BIT])
            begin
                stim_q.push_back(op(FUNC_WRITE, PORT_DATA, 8'($urandom), 8'($urandom)));
            end
            // now and then a stray transaction lands inside the sequence
            if ($urandom_range(0, 4) == 0)
            begin
                stim_q.insert($urandom_range(1, stim_q.size()), rand_txn());
            end
            wd = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00;
            stim_q.push_back(op(FUNC_WRITE, PORT_DATA, wd, 8'($urandom)));
        end
        else if (pick < 30)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                line_levels = 8'($urandom);
            end
            else
            begin
                line_levels = line_levels ^ (8'd1 << $urandom_range(0, 7));
            end
            stim_q.push_back(op(FUNC_SAMPLE, 1'($urandom), 8'($urandom), line_levels));
        end
        else if (pick < 55)
        begin
            stim_q.push_back(op(FUNC_ACK, 1'($urandom), 8'($urandom), 8'($urandom)));
        end
        else if (pick < 67)
        begin
            stim_q.push_back(op(FUNC_READ, 1'($urandom), 8'($urandom), 8'($urandom)));
        end
        else if (pick < 75)
        begin
            // EOI, occasionally one of the ignored OCW2 codes
            if ($urandom_range(0, 3) == 0)
            begin
                wd = {3'($urandom), 2'b00, 3'($urandom)};
            end
            else
            begin
                wd = {($urandom_range(0, 1) == 1) ? EOI_SPEC : EOI_NONSPEC, 2'b00,
                      3'($urandom)};
            end
            stim_q.push_back(op(FUNC_WRITE, PORT_CMD, wd, 8'($urandom)));
        end
        else if (pick < 81)
        begin
            wd = {3'($urandom), 2'b01, 3'($urandom)};
            stim_q.push_back(op(FUNC_WRITE, PORT_CMD, wd, 8'($urandom)));
        end
        else if (pick < 88)
        begin
            wd = ($urandom_range(0, 1) == 0) ? 8'($urandom) : (8'd1 << $urandom_range(0, 7));
            stim_q.push_back(op(FUNC_WRITE, PORT_DATA, wd, 8'($urandom)));
        end
        else
        begin
            stim_q.push_back(rand_txn());
        end
    endtask

    // Offer one transaction after a random gap (none in a burst) and hold it until taken
    task automatic send(txn_t t, logic fixed, answer_t ans, bit burst);
        int gap;
        answer_t due;
        gap = burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.func          <= t.f;
        in_ch.port_select   <= t.port;
        in_ch.write_data    <= t.wd;
        in_ch.request_lines <= t.lines;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        due = next_answer(t);
        answers_due.push_back(fixed ? ans : due);
    endtask

    // Transaction source and end of run
    initial
    begin
        dir_row_t plan[$];
        in_ch.valid         <= 1'b0;
        in_ch.func          <= FUNC_READ;
        in_ch.port_select   <= PORT_CMD;
        in_ch.write_data    <= 8'h00;
        in_ch.request_lines <= 8'h00;
        m_phase   = PHASE_READY;
        m_ic4     = 1'b0;
        m_sngl    = 1'b0;
        m_ltim    = 1'b0;
        m_aeoi    = 1'b0;
        m_base    = 5'd0;
        m_cascade = 8'h00;
        m_imr     = 8'h00;
        m_irr     = 8'h00;
        m_isr     = 8'h00;
        m_ris     = 1'b0;
        m_last    = 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan = '{
            // reset values, spurious vector with base 0
            '{op(FUNC_READ,   PORT_CMD,  8'h00, 8'h00), 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 1'b0}},
            '{op(FUNC_READ,   PORT_DATA, 8'hFF, 8'hFF), 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 1'b0}},
            '{op(FUNC_ACK,    PORT_CMD,  8'h00, 8'h00), 1'b1, '{8'h00, 8'h07, 1'b1, 1'b0, 1'b0}},
            '{op(FUNC_SAMPLE, PORT_CMD,  8'h00, 8'hFF), 1'b0, NO_ANS},
            // full init: ICW1 clears state, command word ignored mid-init
            '{op(FUNC_WRITE,  PORT_CMD,  8'h11, 8'h00), 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 1'b1}},
            '{op(FUNC_WRITE,  PORT_CMD,  8'h20, 8'h00), 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 1'b1}},
            '{op(FUNC_WRITE,  PORT_DATA, 8'hF8, 8'h00), 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 1'b1}},
            '{op(FUNC_WRITE,  PORT_DATA, 8'h04, 8'h00), 1'b0, NO_ANS},
            '{op(FUNC_WRITE,  PORT_DATA, 8'h01, 8'h00), 1'b0, NO_ANS},
            // all lines rise, IR0 masked, IR1 wins
            '{op(FUNC_SAMPLE, PORT_DATA, 8'h00, 8'hFF), 1'b0, NO_ANS},
            '{op(FUNC_WRITE,  PORT_DATA, 8'h01, 8'h00), 1'b0, NO_ANS},
            '{op(FUNC_ACK,    PORT_DATA, 8'h00, 8'h00), 1'b0, NO_ANS},
            '{op(FUNC_WRITE,  PORT_CMD,  8'h0B, 8'h00), 1'b0, NO_ANS},
            '{op(FUNC_READ,   PORT_CMD,  8'h00, 8'h00), 1'b0, NO_ANS},
            // only masked IR0 outranks IR1: spurious at base 31
            '{op(FUNC_ACK,    PORT_CMD,  8'h00, 8'h00), 1'b0, NO_ANS},
            '{op(FUNC_WRITE,  PORT_CMD,  8'h20, 8'h00), 1'b0, NO_ANS},
            '{op(FUNC_WRITE,  PORT_CMD,  8'hA0, 8'h00), 1'b0, NO_ANS},
            '{op(FUNC_ACK,    PORT_CMD,  8'h00, 8'h00), 1'b0, NO_ANS},
            '{op(FUNC_WRITE,  PORT_CMD,  8'h62, 8'h00), 1'b0, NO_ANS},
            '{op(FUNC_WRITE,  PORT_CMD,  8'h0A, 8'h00), 1'b0, NO_ANS},
            // single chip, level triggered, auto EOI
            '{op(FUNC_WRITE,  PORT_CMD,  8'h1B, 8'h00), 1'b0, NO_ANS},
            '{op(FUNC_WRITE,  PORT_DATA, 8'h00, 8'h00), 1'b0, NO_ANS},
            '{op(FUNC_WRITE,  PORT_DATA, 8'h02, 8'h00), 1'b0, NO_ANS},
            '{op(FUNC_SAMPLE, PORT_CMD,  8'h00, 8'h80), 1'b0, NO_ANS},
            '{op(FUNC_ACK,    PORT_CMD,  8'h00, 8'h00), 1'b0, NO_ANS},
            // everything masked: requests stay but the answer is spurious
            '{op(FUNC_WRITE,  PORT_DATA, 8'hFF, 8'h00), 1'b0, NO_ANS},
            '{op(FUNC_SAMPLE, PORT_CMD,  8'h00, 8'h7F), 1'b0, NO_ANS},
            '{op(FUNC_ACK,    PORT_CMD,  8'h00, 8'h00), 1'b0, NO_ANS}
        };
        foreach (plan[i])
        begin
            send(plan[i].t, plan[i].fixed, plan[i].ans, 1'b0);
        end

        for (int n = 0; n < RANDOM_TXNS; n++)
        begin
            if (stim_q.size() == 0)
            begin
                plan_random();
            end
            send(stim_q.pop_front(), 1'b0, NO_ANS, ((n / 150) % 4) == 2);
        end
        in_ch.valid <= 1'b0;

        while (answers_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Result sink: random stalls, bursts, and one long hold-off
    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (results_taken == HOLD_AT)
            begin
                stall = HOLD_CYCLES;
            end
            else if (((results_taken / 170) % 4) == 1)
            begin
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, MAX_WAIT);
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
            begin
                @(posedge clk);
            end
            results_taken++;
        end
    end

    function automatic void check_field(string name, logic [7:0] exp, logic [7:0] got);
        if (got !== exp)
        begin
            $error("%s: expected %0h, got %0h", name, exp, got);
            mismatches++;
        end
    endfunction

    // Compare each result transaction with the oldest answer due
    always @(posedge clk)
    begin
        answer_t due;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (answers_due.size() == 0)
            begin
                $error("result transaction with no answer due");
                mismatches++;
            end
            else
            begin
                due = answers_due.pop_front();
                check_field("read_data",    due.rd,        out_ch.read_data);
                check_field("vector",       due.vec,       out_ch.vector);
                check_field("vector_valid", 8'(due.vv),    8'(out_ch.vector_valid));
                check_field("int_pending",  8'(due.pend),  8'(out_ch.int_pending));
                check_field("init_busy",    8'(due.busy),  8'(out_ch.init_busy));
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
`default_nettype wire
